[hdl/utf8_stream_decoder_top_macros.svh]
// Assertion macros for the checker file of the UTF-8 stream decoder.
// Depends on signals named clk and rst_n in the scope of each use.
`ifndef UTF8_STREAM_DECODER_TOP_MACROS_SVH
`define UTF8_STREAM_DECODER_TOP_MACROS_SVH

// Property checked outside reset.
`define U8SD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define U8SD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/u8sd_pkg.sv]
// Shared constants, types and functions of the UTF-8 stream decoder.
// No dependencies; used by every other file of the block but the assertion macros.
package u8sd_pkg;

  localparam int unsigned MAX_CHARS = 1024;
  localparam int unsigned KEPT_W    = $clog2(MAX_CHARS + 1);
  localparam int unsigned CP_W      = 32;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CCNT_W    = 3;
  localparam int unsigned MAX_PUSH  = 3;
  localparam int unsigned RES_DEPTH = 8;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  localparam logic [1:0]        CONT_TAG  = 2'b10;
  localparam logic [5:0]        CONT_MASK = 6'h3F;
  localparam logic [CCNT_W-1:0] CONT_SAT  = 3'd5;
  localparam logic [BYTE_W-1:0] MASK_LEN1 = 8'h7F;
  localparam logic [BYTE_W-1:0] MASK_LEN2 = 8'h1F;
  localparam logic [BYTE_W-1:0] MASK_LEN3 = 8'h0F;
  localparam logic [BYTE_W-1:0] MASK_LEN4 = 8'h07;
  localparam logic [CP_W-1:0]   CP_LF     = 32'd10;
  localparam logic [CP_W-1:0]   CP_CR     = 32'd13;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic             is_terminator;
    logic [CNT_W-1:0] char_count;
  } res_t;

  typedef struct packed {
    logic [MAX_PUSH-1:0] vld;
    res_t [MAX_PUSH-1:0] item;
  } push_t;

  function automatic logic [CP_W-1:0] char_value(logic [BYTE_W-1:0] lead,
                                                 logic [CP_W-1:0]   cbits,
                                                 logic [CCNT_W-1:0] ccount);
    logic [CP_W-1:0] lead_part;
    case (ccount)
      3'd0:    lead_part = {24'd0, lead & MASK_LEN1};
      3'd1:    lead_part = {24'd0, lead & MASK_LEN2} << 6;
      3'd2:    lead_part = {24'd0, lead & MASK_LEN3} << 12;
      3'd3:    lead_part = {24'd0, lead & MASK_LEN4} << 18;
      default: lead_part = '0;
    endcase
    return lead_part | cbits;
  endfunction

  function automatic logic is_dropped(logic [CP_W-1:0] v);
    return (v == CP_LF) || (v == CP_CR);
  endfunction

  function automatic logic [KEPT_W-1:0] kept_inc(logic [KEPT_W-1:0] k);
    return (k < KEPT_W'(MAX_CHARS)) ? k + KEPT_W'(1) : k;
  endfunction

endpackage

[hdl/u8sd_ifs.sv]
// Channel interfaces of the UTF-8 stream decoder: byte input and result output.
// Depends on u8sd_pkg for field widths.
interface u8sd_in_if;
  logic                        valid;
  logic                        ready;
  logic [u8sd_pkg::BYTE_W-1:0] byte_in;
  logic                        end_of_string;

  modport source(output valid, output byte_in, output end_of_string, input ready);
  modport sink(input valid, input byte_in, input end_of_string, output ready);
endinterface

interface u8sd_out_if;
  logic                       valid;
  logic                       ready;
  logic [u8sd_pkg::CP_W-1:0]  code_point;
  logic                       is_terminator;
  logic [u8sd_pkg::CNT_W-1:0] char_count;

  modport source(output valid, output code_point, output is_terminator,
                 output char_count, input ready);
  modport sink(input valid, input code_point, input is_terminator,
               input char_count, output ready);
endinterface

[hdl/u8sd_decode.sv]
// Decoder state and per-byte result generation: up to three results per request.
// Depends on u8sd_pkg.
module u8sd_decode (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_fire,
  input  logic [u8sd_pkg::BYTE_W-1:0] byte_in,
  input  logic                        end_of_string,
  output u8sd_pkg::push_t             push
);

  logic [u8sd_pkg::BYTE_W-1:0] lead_r, lead_nxt, lead_a;
  logic [u8sd_pkg::CP_W-1:0]   cbits_r, cbits_nxt, cbits_a;
  logic [u8sd_pkg::CCNT_W-1:0] ccount_r, ccount_nxt, ccount_a;
  logic                        pending_r, pending_nxt;
  logic [u8sd_pkg::KEPT_W-1:0] kept_r, kept_nxt, kept_a, kept_b;
  logic                        is_cont, emit_old, emit_new;
  logic [u8sd_pkg::CP_W-1:0]   old_v, new_v;

  always_comb begin
    is_cont  = pending_r && (byte_in[7:6] == u8sd_pkg::CONT_TAG);
    old_v    = u8sd_pkg::char_value(lead_r, cbits_r, ccount_r);
    emit_old = pending_r && !is_cont && !u8sd_pkg::is_dropped(old_v);
    kept_a   = emit_old ? u8sd_pkg::kept_inc(kept_r) : kept_r;

    if (is_cont) begin
      lead_a   = lead_r;
      cbits_a  = {cbits_r[u8sd_pkg::CP_W-7:0], byte_in[5:0] & u8sd_pkg::CONT_MASK};
      ccount_a = (ccount_r < u8sd_pkg::CONT_SAT) ? ccount_r + 3'd1 : ccount_r;
    end else begin
      lead_a   = byte_in;
      cbits_a  = '0;
      ccount_a = '0;
    end

    new_v    = u8sd_pkg::char_value(lead_a, cbits_a, ccount_a);
    emit_new = end_of_string && !u8sd_pkg::is_dropped(new_v);
    kept_b   = emit_new ? u8sd_pkg::kept_inc(kept_a) : kept_a;

    push.vld     = in_fire ? {end_of_string, emit_new, emit_old} : '0;
    push.item[0] = '{code_point: old_v, is_terminator: 1'b0, char_count: '0};
    push.item[1] = '{code_point: new_v, is_terminator: 1'b0, char_count: '0};
    push.item[2] = '{code_point: '0, is_terminator: 1'b1,
                     char_count: u8sd_pkg::CNT_W'(kept_b)};

    lead_nxt    = lead_r;
    cbits_nxt   = cbits_r;
    ccount_nxt  = ccount_r;
    pending_nxt = pending_r;
    kept_nxt    = kept_r;
    if (in_fire) begin
      lead_nxt    = lead_a;
      cbits_nxt   = cbits_a;
      ccount_nxt  = ccount_a;
      pending_nxt = !end_of_string;
      kept_nxt    = end_of_string ? '0 : kept_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      kept_r    <= '0;
    end else begin
      pending_r <= pending_nxt;
      kept_r    <= kept_nxt;
    end
  end

  // The character fields are only read while a character is pending.
  always_ff @(posedge clk) begin
    lead_r   <= lead_nxt;
    cbits_r  <= cbits_nxt;
    ccount_r <= ccount_nxt;
  end

endmodule

[hdl/u8sd_res_fifo.sv]
// Result queue: takes up to three results per cycle, hands out one per cycle while popped.
// Depends on u8sd_pkg.
module u8sd_res_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  u8sd_pkg::push_t push,
  output logic            space,
  output logic            head_valid,
  output u8sd_pkg::res_t  head,
  input  logic            pop
);

  u8sd_pkg::res_t                 mem_r [u8sd_pkg::RES_DEPTH];
  logic [u8sd_pkg::RES_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [u8sd_pkg::RES_CNT_W-1:0] count_r, count_nxt;
  logic [u8sd_pkg::RES_PTR_W-1:0] off [u8sd_pkg::MAX_PUSH];
  logic [u8sd_pkg::RES_CNT_W-1:0] npush;
  logic                           do_pop;

  always_comb begin
    npush = '0;
    for (int k = 0; k < u8sd_pkg::MAX_PUSH; k++) begin
      off[k] = u8sd_pkg::RES_PTR_W'(npush);
      npush  = npush + u8sd_pkg::RES_CNT_W'(push.vld[k]);
    end
    head_valid = (count_r != '0);
    head       = mem_r[rd_ptr_r];
    space      = (count_r <= u8sd_pkg::RES_CNT_W'(u8sd_pkg::RES_DEPTH - u8sd_pkg::MAX_PUSH));
    do_pop     = pop && head_valid;
    wr_ptr_nxt = wr_ptr_r + u8sd_pkg::RES_PTR_W'(npush);
    rd_ptr_nxt = rd_ptr_r + u8sd_pkg::RES_PTR_W'(do_pop);
    count_nxt  = count_r + npush - u8sd_pkg::RES_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < u8sd_pkg::MAX_PUSH; k++) begin
      if (push.vld[k]) begin
        mem_r[wr_ptr_r + off[k]] <= push.item[k];
      end
    end
  end

endmodule

[hdl/utf8_stream_decoder_top.sv]
// Channel     | Dir | Payload                                     | Handshake
// in_chan     | in  | byte_in[7:0], end_of_string                 | valid/ready
// out_chan    | out | code_point[31:0], is_terminator, char_count | valid/ready
//
// One byte request is taken per cycle while the queue has space; its results enter the
// result queue at the next edge and appear on out_chan in order, one per cycle while ready.
// A byte yields up to three results; the eight-entry result queue takes a request
// only while three entries are free, so a stalled output stops input after a few bytes.
// Reset is synchronous and active low; it empties the queue and starts a new string.
// Depends on u8sd_pkg, u8sd_ifs, u8sd_decode and u8sd_res_fifo.
module utf8_stream_decoder_top (
  input  logic              clk,
  input  logic              rst_n,
  u8sd_in_if.sink           in_chan,
  u8sd_out_if.source        out_chan
);

  u8sd_pkg::push_t push;
  u8sd_pkg::res_t  head;
  logic            space;
  logic            head_valid;
  logic            in_fire;

  assign in_chan.ready = space;
  assign in_fire       = in_chan.valid && space;

  u8sd_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .byte_in       (in_chan.byte_in),
    .end_of_string (in_chan.end_of_string),
    .push          (push)
  );

  u8sd_res_fifo u_res_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .space      (space),
    .head_valid (head_valid),
    .head       (head),
    .pop        (out_chan.ready)
  );

  assign out_chan.valid         = head_valid;
  assign out_chan.code_point    = head.code_point;
  assign out_chan.is_terminator = head.is_terminator;
  assign out_chan.char_count    = head.char_count;

endmodule

[hdl/u8sd_checker.sv]
// Port-level checks of the UTF-8 stream decoder's result channel, bound to the top.
// Depends on u8sd_pkg and utf8_stream_decoder_top_macros.svh.
`include "utf8_stream_decoder_top_macros.svh"

module u8sd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [u8sd_pkg::CP_W-1:0]  out_code_point,
  input logic                       out_is_terminator,
  input logic [u8sd_pkg::CNT_W-1:0] out_char_count
);

  `U8SD_ASSERT_RST(a_idle_after_reset, !rst_n |=> !out_valid, "result valid after reset")
  `U8SD_ASSERT(a_hold_on_stall,
               out_valid && !out_ready |=> out_valid && $stable(out_code_point)
                 && $stable(out_is_terminator) && $stable(out_char_count),
               "stalled result changed")
  `U8SD_ASSERT(a_term_no_value,
               out_valid && out_is_terminator |-> out_code_point == '0,
               "terminator carries a code point")
  `U8SD_ASSERT(a_char_no_count,
               out_valid && !out_is_terminator |-> out_char_count == '0,
               "character carries a count")

endmodule

bind utf8_stream_decoder_top u8sd_checker u_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_code_point    (out_chan.code_point),
  .out_is_terminator (out_chan.is_terminator),
  .out_char_count    (out_chan.char_count)
);

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for utf8_stream_decoder_top: byte requests go in through in_chan, and
// each decoded character or terminator is checked against an in-bench decoder model.
// Depends on u8sd_pkg, the channel interfaces in u8sd_ifs and the decoder RTL.
module tb_top;

  typedef struct {
    logic [u8sd_pkg::BYTE_W-1:0] data;
    logic                        eos;
  } byte_req_t;

  logic clk;
  logic rst_n;

  u8sd_in_if  in_ch();
  u8sd_out_if out_ch();

  utf8_stream_decoder_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  byte_req_t      byte_q[$];
  u8sd_pkg::res_t pending_results[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  int unsigned err_cnt        = 0;
  int unsigned bytes_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned strings_closed = 0;

  // Decoder model state.
  logic [u8sd_pkg::BYTE_W-1:0] cur_lead;
  logic [u8sd_pkg::CP_W-1:0]   cur_cbits;
  logic [u8sd_pkg::CCNT_W-1:0] cur_ccount;
  logic                        building;
  int unsigned                 kept;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.byte_in = '0;
    in_ch.end_of_string = 1'b0;
    out_ch.ready = 1'b0;
    cur_lead = '0;
    cur_cbits = '0;
    cur_ccount = '0;
    building = 1'b0;
    kept = 0;
  end

  always #1 clk = ~clk;

  function void emit_char();
    logic [u8sd_pkg::CP_W-1:0] v;
    u8sd_pkg::res_t            r;
    case (cur_ccount)
      3'd0:    v = {24'd0, cur_lead & u8sd_pkg::MASK_LEN1};
      3'd1:    v = {24'd0, cur_lead & u8sd_pkg::MASK_LEN2} << 6;
      3'd2:    v = {24'd0, cur_lead & u8sd_pkg::MASK_LEN3} << 12;
      3'd3:    v = {24'd0, cur_lead & u8sd_pkg::MASK_LEN4} << 18;
      default: v = '0;
    endcase
    v = v | cur_cbits;
    if (v != u8sd_pkg::CP_LF && v != u8sd_pkg::CP_CR) begin
      r.code_point = v;
      r.is_terminator = 1'b0;
      r.char_count = '0;
      pending_results.push_back(r);
      if (kept < u8sd_pkg::MAX_CHARS) kept++;
    end
  endfunction

  function void decode_byte(logic [u8sd_pkg::BYTE_W-1:0] b, logic eos);
    u8sd_pkg::res_t r;
    if (building && b[7:6] == u8sd_pkg::CONT_TAG) begin
      cur_cbits = {cur_cbits[u8sd_pkg::CP_W-7:0], b[5:0] & u8sd_pkg::CONT_MASK};
      if (cur_ccount < u8sd_pkg::CONT_SAT) cur_ccount = cur_ccount + 3'd1;
    end else begin
      if (building) emit_char();
      cur_lead = b;
      cur_cbits = '0;
      cur_ccount = '0;
      building = 1'b1;
    end
    if (eos) begin
      emit_char();
      r.code_point = '0;
      r.is_terminator = 1'b1;
      r.char_count = u8sd_pkg::CNT_W'(kept);
      pending_results.push_back(r);
      strings_closed++;
      cur_lead = '0;
      cur_cbits = '0;
      cur_ccount = '0;
      building = 1'b0;
      kept = 0;
    end
  endfunction

  always @(posedge clk) begin : drive_proc
    byte_req_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.byte_in, in_ch.end_of_string);
        bytes_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = byte_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.byte_in <= nxt.data;
          in_ch.end_of_string <= nxt.eos;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin : check_proc
    u8sd_pkg::res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("unexpected result: code_point %h, is_terminator %b, char_count %0d",
                 out_ch.code_point, out_ch.is_terminator, out_ch.char_count);
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.code_point !== want.code_point) begin
            $error("code_point: expected %h, got %h", want.code_point, out_ch.code_point);
            err_cnt++;
          end
          if (out_ch.is_terminator !== want.is_terminator) begin
            $error("is_terminator: expected %b, got %b", want.is_terminator,
                   out_ch.is_terminator);
            err_cnt++;
          end
          if (out_ch.char_count !== want.char_count) begin
            $error("char_count: expected %0d, got %0d", want.char_count, out_ch.char_count);
            err_cnt++;
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task put_byte(input logic [u8sd_pkg::BYTE_W-1:0] b, input logic eos);
    byte_req_t r;
    r.data = b;
    r.eos = eos;
    byte_q.push_back(r);
  endtask

  function automatic logic [u8sd_pkg::BYTE_W-1:0] cont_byte();
    return {u8sd_pkg::CONT_TAG, 6'($urandom_range(0, 63))};
  endfunction

  // One string of n_chars characters, mostly well formed, ending with end_of_string.
  task add_string(input int n_chars);
    int kind;
    int n;
    for (int i = 0; i < n_chars; i++) begin
      kind = $urandom_range(0, 15);
      case (kind)
        0: begin
          n = $urandom_range(0, 3);
          put_byte((n == 0) ? 8'h00 : (n == 1) ? 8'h0A : (n == 2) ? 8'h0D : 8'h7F, 1'b0);
        end
        1, 2, 3, 4: put_byte(8'($urandom_range(0, 127)), 1'b0);
        5, 6, 7: begin
          put_byte({3'b110, 5'($urandom_range(0, 31))}, 1'b0);
          put_byte(cont_byte(), 1'b0);
        end
        8, 9: begin
          put_byte({4'b1110, 4'($urandom_range(0, 15))}, 1'b0);
          repeat (2) put_byte(cont_byte(), 1'b0);
        end
        10, 11: begin
          put_byte({5'b11110, 3'($urandom_range(0, 7))}, 1'b0);
          repeat (3) put_byte(cont_byte(), 1'b0);
        end
        12: put_byte(cont_byte(), 1'b0);
        13: begin
          put_byte({5'b11111, 3'($urandom_range(0, 7))}, 1'b0);
          n = $urandom_range(4, 7);
          repeat (n) put_byte(cont_byte(), 1'b0);
        end
        14: begin
          put_byte({4'b1111, 4'($urandom_range(0, 15))}, 1'b0);
          n = $urandom_range(0, 2);
          repeat (n) put_byte(cont_byte(), 1'b0);
        end
        default: put_byte(8'($urandom), 1'b0);
      endcase
    end
    byte_q[$].eos = 1'b1;
  endtask

  task fill_random(input int n_bytes);
    int start;
    start = byte_q.size();
    while (byte_q.size() - start < n_bytes) add_string($urandom_range(1, 10));
  endtask

  task drain();
    while (byte_q.size() != 0 || in_ch.valid || pending_results.size() != 0)
      @(negedge clk);
  endtask

  task run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                 input int n_bytes);
    @(negedge clk);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    fill_random(n_bytes);
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero byte, a continuation opening a string, then the standard lengths.
    put_byte(8'h00, 1'b1);
    put_byte(8'hBF, 1'b0);
    put_byte(8'h80, 1'b1);
    put_byte(8'hC3, 1'b0);
    put_byte(8'hA9, 1'b0);
    put_byte(8'hE2, 1'b0);
    put_byte(8'h82, 1'b0);
    put_byte(8'hAC, 1'b0);
    put_byte(8'hF0, 1'b0);
    put_byte(8'h9F, 1'b0);
    put_byte(8'h98, 1'b0);
    put_byte(8'h80, 1'b0);
    // Line feed, carriage return and an overlong line feed are all dropped.
    put_byte(8'h0A, 1'b0);
    put_byte(8'h0D, 1'b0);
    put_byte(8'hC0, 1'b0);
    put_byte(8'h8A, 1'b1);
    // A run longer than four bytes, then an all-ones byte alone.
    put_byte(8'hFF, 1'b0);
    put_byte(8'hBF, 1'b0);
    put_byte(8'h80, 1'b0);
    put_byte(8'hBF, 1'b0);
    put_byte(8'h80, 1'b0);
    put_byte(8'hBF, 1'b0);
    put_byte(8'hBF, 1'b1);
    put_byte(8'hFF, 1'b1);
    put_byte(8'h7F, 1'b1);
    drain();

    run_phase(0, 0, 50);
    run_phase(68, 0, 50);
    run_phase(0, 68, 50);
    run_phase(34, 34, 50);

    // Output held off for a long stretch while bytes keep coming.
    @(posedge clk);
    hold_left <= 300;
    run_phase(0, 0, 55);

    repeat (20) @(posedge clk);
    $display("Sent %0d bytes in %0d strings and checked %0d results,", bytes_sent,
             strings_closed, results_seen);
    $display("covering all lengths, overlong and stray bytes, drops and output stalls.");
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #400us;
    $display("Timeout with %0d results still expected.", pending_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
